[rtl/kle_pkg.sv]
// ----------------------------------------------------------------------------
// kle_pkg
// Shared types and constants for the keyboard line editor: key codes, event
// codes, the command classes passed from front to back, and store geometry.
// ----------------------------------------------------------------------------
package kle_pkg;

    // Store geometry
    localparam int STORE_DEPTH = 256;
    localparam int LINE_LIMIT  = 255;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int BANK_DEPTH  = STORE_DEPTH / 2;
    localparam int BANK_AW     = IDX_W - 1;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [6:0]       key_t;

    // Control characters
    localparam key_t KEY_NONE   = 7'h00;
    localparam key_t KEY_CANCEL = 7'h18;
    localparam key_t KEY_STOP   = 7'h17;
    localparam key_t KEY_CONT   = 7'h12;
    localparam key_t KEY_ERASE  = 7'h7f;
    localparam key_t KEY_CR     = 7'h0d;
    localparam key_t KEY_LF     = 7'h0a;

    localparam idx_t LIMIT_IDX  = IDX_W'(LINE_LIMIT);

    // Result event codes
    typedef enum logic [3:0] {
        EV_STORED    = 4'd0,
        EV_ERASED    = 4'd1,
        EV_ERASE_IGN = 4'd2,
        EV_LINE      = 4'd3,
        EV_CANCEL    = 4'd4,
        EV_STOP      = 4'd5,
        EV_CONT      = 4'd6,
        EV_OVERFLOW  = 4'd7,
        EV_SINGLE    = 4'd8
    } event_t;

    // Command class decided by the front part
    typedef enum logic [2:0] {
        CMD_SINGLE,
        CMD_LINE,
        CMD_CANCEL,
        CMD_STOP,
        CMD_CONT,
        CMD_ERASE,
        CMD_CHAR
    } cmd_t;

    // One queued command
    typedef struct packed {
        cmd_t cmd;
        key_t key;
    } cmd_entry_t;

    // One result
    typedef struct packed {
        event_t ev;
        key_t   echo_char;
        idx_t   line_length;
        logic   char_written;
        idx_t   char_index;
        logic   zero_written;
        idx_t   zero_index;
    } result_t;

endpackage

[rtl/kle_front.sv]
// ----------------------------------------------------------------------------
// kle_front
// Input side: accepts characters, drops the null code and classifies each
// character into a command for the back part.
// ----------------------------------------------------------------------------
module kle_front
    import kle_pkg::*;
(
    input  logic       s_valid,
    output logic       s_ready,
    input  key_t       s_key_code,
    input  logic       single_char_mode,
    input  logic       q_ready,
    output logic       q_push,
    output cmd_entry_t q_entry
);

    // Accept whenever the queue has room; a null code is taken and dropped
    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready && (s_key_code != KEY_NONE);

    // Classify the character
    always_comb begin
        q_entry.key = s_key_code;
        if (single_char_mode) begin
            q_entry.cmd = CMD_SINGLE;
        end else begin
            case (s_key_code)
                KEY_CR, KEY_LF: q_entry.cmd = CMD_LINE;
                KEY_CANCEL:     q_entry.cmd = CMD_CANCEL;
                KEY_STOP:       q_entry.cmd = CMD_STOP;
                KEY_CONT:       q_entry.cmd = CMD_CONT;
                KEY_ERASE:      q_entry.cmd = CMD_ERASE;
                default:        q_entry.cmd = CMD_CHAR;
            endcase
        end
    end

endmodule

[rtl/kle_queue.sv]
// ----------------------------------------------------------------------------
// kle_queue
// Short command queue between the front and back parts so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module kle_queue
    import kle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cmd_entry_t push_entry,
    output logic       push_ready,
    input  logic       pop,
    output logic       head_valid,
    output cmd_entry_t head_entry
);

    cmd_entry_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    assign do_push = push && push_ready;
    assign do_pop  = pop && head_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entries in their slots
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Occupancy never exceeds the queue depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

    // Pointers differ by the occupancy (modulo depth)
    a_ptr_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with occupancy");

endmodule

[rtl/kle_back.sv]
// ----------------------------------------------------------------------------
// kle_back
// Execution side: applies each command to the write index and the line
// store, and holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module kle_back
    import kle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  cmd_entry_t head_entry,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    m_result
);

    idx_t    write_index_reg, write_index_next;
    logic    m_valid_reg, m_valid_next;
    result_t result_reg, result_next;

    // Line store split into even and odd banks: the character and its
    // terminator always land in opposite banks, one write per bank
    logic [6:0]         even_mem [BANK_DEPTH];
    logic [6:0]         odd_mem  [BANK_DEPTH];
    logic               even_we, odd_we;
    logic [BANK_AW-1:0] even_addr, odd_addr;
    key_t               even_data, odd_data;

    assign pop = head_valid && (!m_valid_reg || m_ready);

    // Execute the head command
    always_comb begin
        write_index_next         = write_index_reg;
        result_next.ev           = EV_STOP;
        result_next.echo_char    = KEY_NONE;
        result_next.char_written = 1'b0;
        result_next.char_index   = '0;
        result_next.zero_written = 1'b0;
        result_next.zero_index   = '0;
        case (head_entry.cmd)
            CMD_SINGLE: begin
                write_index_next         = '0;
                result_next.zero_written = 1'b1;
                result_next.ev           = EV_SINGLE;
            end
            CMD_LINE: begin
                write_index_next = '0;
                result_next.ev   = EV_LINE;
            end
            CMD_CANCEL: begin
                write_index_next         = '0;
                result_next.zero_written = 1'b1;
                result_next.ev           = EV_CANCEL;
            end
            CMD_STOP: begin
                result_next.ev = EV_STOP;
            end
            CMD_CONT: begin
                result_next.ev = EV_CONT;
            end
            CMD_ERASE: begin
                if (write_index_reg != '0) begin
                    write_index_next         = write_index_reg - 1'b1;
                    result_next.zero_written = 1'b1;
                    result_next.zero_index   = write_index_reg - 1'b1;
                    result_next.ev           = EV_ERASED;
                end else begin
                    result_next.ev = EV_ERASE_IGN;
                end
            end
            CMD_CHAR: begin
                if (write_index_reg >= LIMIT_IDX) begin
                    write_index_next = '0;
                    result_next.ev   = EV_OVERFLOW;
                end else begin
                    write_index_next         = write_index_reg + 1'b1;
                    result_next.char_written = 1'b1;
                    result_next.char_index   = write_index_reg;
                    result_next.zero_written = 1'b1;
                    result_next.zero_index   = write_index_reg + 1'b1;
                    result_next.echo_char    = head_entry.key;
                    result_next.ev           = EV_STORED;
                end
            end
            default: begin
                result_next.ev = EV_STOP;
            end
        endcase
        result_next.line_length = write_index_next;
    end

    // Route the two writes to their banks
    always_comb begin
        even_we   = 1'b0;
        odd_we    = 1'b0;
        even_addr = result_next.zero_index[IDX_W-1:1];
        odd_addr  = result_next.zero_index[IDX_W-1:1];
        even_data = KEY_NONE;
        odd_data  = KEY_NONE;
        if (pop && result_next.zero_written) begin
            if (result_next.zero_index[0]) begin
                odd_we = 1'b1;
            end else begin
                even_we = 1'b1;
            end
        end
        if (pop && result_next.char_written) begin
            if (result_next.char_index[0]) begin
                odd_we    = 1'b1;
                odd_addr  = result_next.char_index[IDX_W-1:1];
                odd_data  = head_entry.key;
            end else begin
                even_we   = 1'b1;
                even_addr = result_next.char_index[IDX_W-1:1];
                even_data = head_entry.key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (even_we) begin
            even_mem[even_addr] <= even_data;
        end
        if (odd_we) begin
            odd_mem[odd_addr] <= odd_data;
        end
    end

    // Hold the result until the transfer completes
    always_comb begin
        m_valid_next = pop || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_index_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                write_index_reg <= write_index_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    // Write index stays within the line limit
    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        write_index_reg <= LIMIT_IDX)
        else $error("write index beyond line limit");

    // A terminator always lands at the new write index
    a_zero_at_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.zero_written) |-> (result_reg.zero_index == result_reg.line_length))
        else $error("terminator not at line end");

    // A stored character sits just before the new write index
    a_char_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.char_written) |->
            (result_reg.line_length == result_reg.char_index + 1'b1))
        else $error("stored character position mismatch");

    // Write index only moves when a command is executed
    a_index_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> $stable(write_index_reg))
        else $error("write index moved without a command");

endmodule

[rtl/keyboard_line_editor.sv]
// ----------------------------------------------------------------------------
// keyboard_line_editor
// Canonical line editor for received keyboard characters.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_key_code carry one received character per transfer.
//   m_valid/m_ready and the m_ fields carry one result per character; a
//   null character code is taken and produces no result.
//   cfg_we/cfg_wdata write the single-character mode bit; write it only
//   while no character is in flight.
// Path: each character is registered in the command queue, then its result
//   in the output register. Throughput: one character per cycle while
//   m_ready stays high; the index update and the two store writes (character
//   and terminator, in opposite even/odd banks) take effect together.
// Reset: synchronous, active low; the write index returns to zero, the mode
//   bit to buffered editing, the queue and output register empty. The line
//   store is not cleared.
// Stall: a held result keeps m_ fields stable; the two-entry command queue
//   keeps taking characters until it is full, then s_ready falls.
// ----------------------------------------------------------------------------
module keyboard_line_editor
    import kle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [6:0] s_key_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_event_res,
    output logic [6:0] m_echo_char,
    output logic [7:0] m_line_length,
    output logic       m_char_written,
    output logic [7:0] m_char_index,
    output logic       m_zero_written,
    output logic [7:0] m_zero_index
);

    logic       single_char_mode_reg;
    logic       q_push, q_ready, q_pop, q_head_valid;
    cmd_entry_t q_push_entry, q_head_entry;
    result_t    result;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            single_char_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            single_char_mode_reg <= cfg_wdata;
        end
    end

    kle_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_key_code       (s_key_code),
        .single_char_mode (single_char_mode_reg),
        .q_ready          (q_ready),
        .q_push           (q_push),
        .q_entry          (q_push_entry)
    );

    kle_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    kle_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (result)
    );

    // Break out the result fields
    assign m_event_res    = 4'(result.ev);
    assign m_echo_char    = result.echo_char;
    assign m_line_length  = 8'(result.line_length);
    assign m_char_written = result.char_written;
    assign m_char_index   = 8'(result.char_index);
    assign m_zero_written = result.zero_written;
    assign m_zero_index   = 8'(result.zero_index);

endmodule

[bench/kle_checker.sv]
// ----------------------------------------------------------------------------
// kle_checker
// Watches both channels of the keyboard line editor and predicts each result
// from its own copy of the write index and the mode bit. Compares every result
// transfer field by field against the oldest prediction and counts mismatches.
// ----------------------------------------------------------------------------
module kle_checker
    import kle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [6:0] s_key_code,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [3:0] m_event_res,
    input  logic [6:0] m_echo_char,
    input  logic [7:0] m_line_length,
    input  logic       m_char_written,
    input  logic [7:0] m_char_index,
    input  logic       m_zero_written,
    input  logic [7:0] m_zero_index,
    output int         expected_left,
    output int         mismatch_count,
    output int         results_checked,
    output int         overflow_seen,
    output int         single_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        single_mode;
    int unsigned line_pos;
    result_t     line_results_q[$];

    // Apply one key to the tracked line and return the result it gives
    function automatic result_t edit_line(input key_t key);
        result_t r;
        r = '0;
        if (single_mode) begin
            line_pos       = 0;
            r.zero_written = 1'b1;
            r.zero_index   = '0;
            r.ev           = EV_SINGLE;
        end else if (key == KEY_CR || key == KEY_LF) begin
            line_pos = 0;
            r.ev     = EV_LINE;
        end else if (key == KEY_CANCEL) begin
            line_pos       = 0;
            r.zero_written = 1'b1;
            r.zero_index   = '0;
            r.ev           = EV_CANCEL;
        end else if (key == KEY_STOP) begin
            r.ev = EV_STOP;
        end else if (key == KEY_CONT) begin
            r.ev = EV_CONT;
        end else if (key == KEY_ERASE) begin
            if (line_pos > 0) begin
                line_pos       = line_pos - 1;
                r.zero_written = 1'b1;
                r.zero_index   = idx_t'(line_pos);
                r.ev           = EV_ERASED;
            end else begin
                r.ev = EV_ERASE_IGN;
            end
        end else if (line_pos >= LINE_LIMIT) begin
            // Line full: drop the character and restart the line
            line_pos = 0;
            r.ev     = EV_OVERFLOW;
        end else begin
            r.char_written = 1'b1;
            r.char_index   = idx_t'(line_pos);
            line_pos       = line_pos + 1;
            // Terminator goes behind the new character while it fits the store
            if (line_pos < STORE_DEPTH) begin
                r.zero_written = 1'b1;
                r.zero_index   = idx_t'(line_pos);
            end
            r.echo_char = key;
            r.ev        = EV_STORED;
        end
        r.line_length = idx_t'(line_pos);
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want, input event_t ev);
        if (got != want) begin
            report_error($sformatf("%s is %0d, expected %0d (event %s)",
                                   name, got, want, ev.name()));
        end
    endtask

    // Predict on input transfers, compare on result transfers
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            single_mode = 1'b0;
            line_pos    = 0;
            line_results_q.delete();
        end else begin
            if (cfg_we) begin
                single_mode = cfg_wdata;
            end
            // A null code is taken without giving a result
            if (s_valid && s_ready && s_key_code != KEY_NONE) begin
                line_results_q.push_back(edit_line(s_key_code));
            end
            if (m_valid && m_ready) begin
                if (line_results_q.size() == 0) begin
                    report_error($sformatf("result transfer with nothing expected, event %0d",
                                           m_event_res));
                end else begin
                    want = line_results_q.pop_front();
                    check_field("event_res", m_event_res, want.ev, want.ev);
                    check_field("echo_char", m_echo_char, want.echo_char, want.ev);
                    check_field("line_length", m_line_length, want.line_length, want.ev);
                    check_field("char_written", m_char_written, want.char_written, want.ev);
                    check_field("char_index", m_char_index, want.char_index, want.ev);
                    check_field("zero_written", m_zero_written, want.zero_written, want.ev);
                    check_field("zero_index", m_zero_index, want.zero_index, want.ev);
                    results_checked++;
                    if (want.ev == EV_OVERFLOW) begin
                        overflow_seen++;
                    end
                    if (want.ev == EV_SINGLE) begin
                        single_seen++;
                    end
                end
            end
        end
        expected_left <= line_results_q.size();
    end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the keyboard line editor. Drives directed keys and
// then random keys in both modes and long lines in buffered mode under three
// idling patterns, including a long receiver pause that fills the block; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kle_pkg::*;

    localparam int HOLD_CYCLES    = 48;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 3000;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       cfg_we     = 1'b0;
    logic       cfg_wdata  = 1'b0;
    logic       s_valid    = 1'b0;
    logic [6:0] s_key_code = 7'h00;
    logic       m_ready    = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [3:0] m_event_res;
    logic [6:0] m_echo_char;
    logic [7:0] m_line_length;
    logic       m_char_written;
    logic [7:0] m_char_index;
    logic       m_zero_written;
    logic [7:0] m_zero_index;

    int expected_left;
    int mismatch_count;
    int results_checked;
    int overflow_seen;
    int single_seen;

    int          send_idle   = 0;
    int          recv_idle   = 0;
    int          pause_req   = 0;
    int          pause_seen  = 0;
    int          hold_left   = 0;
    int          quiet_cycles = 0;
    int          keys_sent   = 0;
    int          null_sent   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    keyboard_line_editor u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_code     (s_key_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_echo_char    (m_echo_char),
        .m_line_length  (m_line_length),
        .m_char_written (m_char_written),
        .m_char_index   (m_char_index),
        .m_zero_written (m_zero_written),
        .m_zero_index   (m_zero_index)
    );

    kle_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_code      (s_key_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_echo_char     (m_echo_char),
        .m_line_length   (m_line_length),
        .m_char_written  (m_char_written),
        .m_char_index    (m_char_index),
        .m_zero_written  (m_zero_written),
        .m_zero_index    (m_zero_index),
        .expected_left   (expected_left),
        .mismatch_count  (mismatch_count),
        .results_checked (results_checked),
        .overflow_seen   (overflow_seen),
        .single_seen     (single_seen)
    );

    // Receiver: random back-pressure, or a long pause when one is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            hold_left  <= 0;
            pause_seen <= 0;
        end else if (pause_seen != pause_req) begin
            pause_seen <= pause_req;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Count cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_left);
        $display("keyboard_line_editor verification failed");
        $finish;
    end

    function automatic logic is_special(input key_t k);
        return k == KEY_NONE || k == KEY_CR || k == KEY_LF || k == KEY_CANCEL ||
               k == KEY_STOP || k == KEY_CONT || k == KEY_ERASE;
    endfunction

    // Any code that is simply stored in buffered mode
    function automatic key_t ordinary_key();
        key_t k;
        do begin
            k = key_t'($urandom_range(1, 127));
        end while (is_special(k));
        return k;
    endfunction

    // Editing traffic: mostly text, with erases, line ends and controls mixed in
    function automatic key_t mixed_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return ordinary_key();
        if (r < 75) return KEY_ERASE;
        if (r < 82) return ($urandom_range(1) != 0) ? KEY_CR : KEY_LF;
        if (r < 86) return KEY_CANCEL;
        if (r < 90) return ($urandom_range(1) != 0) ? KEY_STOP : KEY_CONT;
        if (r < 93) return KEY_NONE;
        return key_t'($urandom_range(0, 127));
    endfunction

    // Offer one key, hold it until transferred, then maybe idle
    task automatic send_key(input key_t k);
        s_valid    <= 1'b1;
        s_key_code <= k;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (k == KEY_NONE) begin
            null_sent++;
        end else begin
            keys_sent++;
        end
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Wait for every expected result, then let the pipeline settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic single);
        cfg_we    <= 1'b1;
        cfg_wdata <= single;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Fill a line to the limit, erase and refill, then overflow it
    task automatic run_long_line();
        int extra;
        extra = $urandom_range(1, 12);
        send_key(KEY_CR);
        for (int i = 0; i < LINE_LIMIT; i++) begin
            if ($urandom_range(29) == 0) begin
                send_key(($urandom_range(1) != 0) ? KEY_STOP : KEY_CONT);
            end
            send_key(ordinary_key());
        end
        send_key(KEY_ERASE);
        send_key(ordinary_key());
        for (int i = 0; i < extra; i++) begin
            send_key(ordinary_key());
        end
    endtask

    task automatic run_mixed(input int count);
        for (int i = 0; i < count; i++) begin
            send_key(mixed_key());
        end
    endtask

    task automatic run_directed();
        key_t keys_q[$];
        keys_q = '{KEY_ERASE, 7'h41, 7'h01, 7'h7e, KEY_ERASE, KEY_CR, KEY_ERASE,
                   7'h20, KEY_LF, KEY_STOP, KEY_CONT, 7'h71, 7'h72, KEY_CANCEL,
                   KEY_NONE, 7'h7a, KEY_NONE, KEY_ERASE, KEY_ERASE};
        foreach (keys_q[i]) begin
            send_key(keys_q[i]);
        end
        wait_drained();
        // Single-character mode clears on every key but the null code, controls included
        write_mode(1'b1);
        keys_q = '{7'h61, KEY_CR, KEY_ERASE, KEY_NONE};
        foreach (keys_q[i]) begin
            send_key(keys_q[i]);
        end
        wait_drained();
    endtask

    // One idling pattern: buffered edits, single-character mode, back again
    task automatic run_phase(input int s_idle, input int r_idle, input logic pressure);
        send_idle = s_idle;
        recv_idle = r_idle;
        write_mode(1'b0);
        if (pressure) begin
            pause_req = pause_req + 1;
            repeat (40) send_key(ordinary_key());
        end
        run_long_line();
        run_mixed(110);
        wait_drained();
        write_mode(1'b1);
        run_mixed(40);
        wait_drained();
        write_mode(1'b0);
        run_mixed(15);
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_mode(1'b0);
        run_directed();

        run_phase(25, 83, 1'b0);
        run_phase(83, 25, 1'b0);
        run_phase(0, 0, 1'b1);

        $display("summary: %0d keys and %0d null codes sent, %0d results checked",
                 keys_sent, null_sent, results_checked);
        $display("summary: %0d line overflows, %0d single-character clears, %0d mismatches",
                 overflow_seen, single_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("keyboard_line_editor verification clean");
        end else begin
            $display("keyboard_line_editor verification failed");
        end
        $finish;
    end

endmodule

[keyboard_line_editor.f]
rtl/kle_pkg.sv
rtl/kle_front.sv
rtl/kle_queue.sv
rtl/kle_back.sv
rtl/keyboard_line_editor.sv
bench/kle_checker.sv
bench/tb_top.sv
